>>> hw/rtl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Field widths, request and status codes, slot entry layout and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package gsa_pkg;

  // Handle layout: generation above slot index.
  localparam int GEN_W      = 16;
  localparam int IDX_FIELD_W = 16;
  localparam int HANDLE_W   = GEN_W + IDX_FIELD_W;
  localparam int SLOT_OUT_W = 6;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // Generation that a fresh or wrapped slot takes.
  localparam logic [GEN_W-1:0] GEN_FIRST = 16'd1;

  // One word of the slot table.
  typedef struct packed {
    logic             alive;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // capture the request and start the first reads
    logic pop;     // free-stack top is ready, read its slot entry
    logic commit;  // evaluate, update the tables and load the result
  } gsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_now;   // incoming request reuses a slot from the free stack
    logic out_free;  // result register can take a new result this cycle
  } gsa_sts_t;

endpackage

>>> hw/rtl/gsa_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one allocator request.
// ----------------------------------------------------------------------------
interface gsa_req_if;
  logic                          valid;
  logic                          ready;
  logic [gsa_pkg::MODE_W-1:0]    mode;
  logic [gsa_pkg::HANDLE_W-1:0]  handle;

  modport source (output valid, output mode, output handle, input ready);
  modport sink   (input valid, input mode, input handle, output ready);
endinterface

>>> hw/rtl/gsa_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one allocator result.
// ----------------------------------------------------------------------------
interface gsa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [gsa_pkg::HANDLE_W-1:0]    result_handle;
  logic [gsa_pkg::SLOT_OUT_W-1:0]  slot;
  logic [gsa_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output result_handle, output slot, output status,
                  input ready);
  modport sink   (input valid, input result_handle, input slot, input status,
                  output ready);
endinterface

>>> hw/rtl/gsa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences each request: capture, optional free-stack read, then commit
// once the result register has room.
// ----------------------------------------------------------------------------
module gsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  gsa_pkg::gsa_sts_t sts,
  output logic              in_ready,
  output gsa_pkg::gsa_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = sts.pop_now ? S_POP : S_EVAL;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/gsa_datapath.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Slot table, free stack, fill counters, request registers and the
// result register.
// ----------------------------------------------------------------------------
module gsa_datapath #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gsa_pkg::gsa_cmd_t                cmd,
  output gsa_pkg::gsa_sts_t                sts,
  input  logic [gsa_pkg::MODE_W-1:0]       req_mode,
  input  logic [gsa_pkg::HANDLE_W-1:0]     req_handle,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [gsa_pkg::HANDLE_W-1:0]     out_handle,
  output logic [gsa_pkg::SLOT_OUT_W-1:0]   out_slot,
  output logic [gsa_pkg::STATUS_W-1:0]     out_status
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W = gsa_pkg::IDX_FIELD_W + 1;

  // Memories: slot table and free stack.
  gsa_pkg::slot_entry_t slot_mem [SLOT_COUNT];
  logic [IDX_W-1:0]     stk_mem  [SLOT_COUNT];

  // Fill counters.
  logic [CNT_W-1:0] slots_used;
  logic [CNT_W-1:0] free_depth;
  logic [CNT_W-1:0] depth_m1;

  // Request registers.
  logic [gsa_pkg::MODE_W-1:0]      mode_q;
  logic [gsa_pkg::GEN_W-1:0]       hgen_q;
  logic [gsa_pkg::HANDLE_W-1:0]    handle_q;
  logic [IDX_W-1:0]                idx_q;
  logic                            known_q;
  logic                            new_q;
  logic                            pop_q;

  // Read side.
  gsa_pkg::slot_entry_t            ent_q;
  logic [IDX_W-1:0]                stk_rd_q;
  logic [IDX_W-1:0]                ent_addr;
  logic                            ent_rd_en;
  logic                            stk_rd_en;

  // Input decode.
  logic [gsa_pkg::IDX_FIELD_W-1:0] hidx;
  logic [gsa_pkg::GEN_W-1:0]       hgen;
  logic                            pop_now;

  // Commit side.
  logic                            current;
  logic [gsa_pkg::GEN_W-1:0]       alloc_gen;
  logic [gsa_pkg::GEN_W-1:0]       bump_gen;
  logic                            ent_we;
  gsa_pkg::slot_entry_t            ent_wdata;
  logic                            stk_we;
  logic                            used_inc;
  logic                            depth_inc;
  logic                            depth_dec;
  logic [gsa_pkg::HANDLE_W-1:0]    res_handle;
  logic [gsa_pkg::IDX_FIELD_W-1:0] res_idx;
  logic [gsa_pkg::STATUS_W-1:0]    res_status;
  logic                            res_hit;

  assign hidx     = req_handle[gsa_pkg::IDX_FIELD_W-1:0];
  assign hgen     = req_handle[gsa_pkg::HANDLE_W-1:gsa_pkg::IDX_FIELD_W];
  assign depth_m1 = free_depth - CNT_W'(1);
  assign pop_now  = (req_mode == gsa_pkg::MODE_ALLOC) && (free_depth != '0);

  assign sts.pop_now  = pop_now;
  assign sts.out_free = !out_valid || out_ready;

  // Read addresses: the handle's slot, the next unused slot, or the
  // slot just taken from the free stack.
  always_comb begin
    if (cmd.pop) begin
      ent_addr = stk_rd_q;
    end else if (req_mode == gsa_pkg::MODE_ALLOC) begin
      ent_addr = slots_used[IDX_W-1:0];
    end else begin
      ent_addr = hidx[IDX_W-1:0];
    end
  end
  assign ent_rd_en = cmd.accept || cmd.pop;
  assign stk_rd_en = cmd.accept && pop_now;

  // Capture the request; only slots below the fill count were ever written.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q   <= req_mode;
      handle_q <= req_handle;
      hgen_q   <= hgen;
      known_q  <= (hgen != '0) && (CMP_W'(hidx) < CMP_W'(slots_used));
      new_q    <= !pop_now && (slots_used < CNT_W'(SLOT_COUNT));
      pop_q    <= pop_now;
      idx_q    <= (req_mode == gsa_pkg::MODE_ALLOC) ? slots_used[IDX_W-1:0]
                                                      : hidx[IDX_W-1:0];
    end else if (cmd.pop) begin
      idx_q    <= stk_rd_q;
    end
  end

  // Evaluate the request against the entry read back.
  assign current   = known_q && ent_q.alive && (ent_q.gen == hgen_q);
  assign alloc_gen = (new_q || (ent_q.gen == '0)) ? gsa_pkg::GEN_FIRST : ent_q.gen;
  assign bump_gen  = (ent_q.gen == '1) ? gsa_pkg::GEN_FIRST
                                       : ent_q.gen + gsa_pkg::GEN_W'(1);
  assign res_idx   = gsa_pkg::IDX_FIELD_W'(idx_q);

  always_comb begin
    ent_we     = 1'b0;
    ent_wdata  = ent_q;
    stk_we     = 1'b0;
    used_inc   = 1'b0;
    depth_inc  = 1'b0;
    depth_dec  = 1'b0;
    res_hit    = 1'b0;
    res_handle = '0;
    res_status = gsa_pkg::STAT_STALE;
    unique case (mode_q)
      gsa_pkg::MODE_LOOKUP: begin
        if (current) begin
          res_hit    = 1'b1;
          res_handle = handle_q;
          res_status = gsa_pkg::STAT_OK;
        end
      end
      gsa_pkg::MODE_ALLOC: begin
        if (pop_q || new_q) begin
          ent_we          = 1'b1;
          ent_wdata.alive = 1'b1;
          ent_wdata.gen   = alloc_gen;
          used_inc        = new_q;
          depth_dec       = pop_q;
          res_hit         = 1'b1;
          res_handle      = {alloc_gen, res_idx};
          res_status      = gsa_pkg::STAT_OK;
        end else begin
          res_status = gsa_pkg::STAT_FULL;
        end
      end
      gsa_pkg::MODE_FREE: begin
        if (current) begin
          ent_we          = 1'b1;
          ent_wdata.alive = 1'b0;
          ent_wdata.gen   = bump_gen;
          stk_we          = free_depth < CNT_W'(SLOT_COUNT);
          depth_inc       = stk_we;
          res_hit         = 1'b1;
          res_handle      = handle_q;
          res_status      = gsa_pkg::STAT_OK;
        end
      end
      default: begin
        res_status = gsa_pkg::STAT_STALE;
      end
    endcase
  end

  // Slot table port.
  always_ff @(posedge clk) begin
    if (ent_rd_en) begin
      ent_q <= slot_mem[ent_addr];
    end
    if (cmd.commit && ent_we) begin
      slot_mem[idx_q] <= ent_wdata;
    end
  end

  // Free stack port.
  always_ff @(posedge clk) begin
    if (stk_rd_en) begin
      stk_rd_q <= stk_mem[depth_m1[IDX_W-1:0]];
    end
    if (cmd.commit && stk_we) begin
      stk_mem[free_depth[IDX_W-1:0]] <= idx_q;
    end
  end

  // Fill counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      free_depth <= '0;
    end else if (cmd.commit) begin
      if (used_inc) begin
        slots_used <= slots_used + CNT_W'(1);
      end
      if (depth_inc) begin
        free_depth <= free_depth + CNT_W'(1);
      end else if (depth_dec) begin
        free_depth <= depth_m1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_handle <= res_handle;
      out_slot   <= res_hit ? res_idx[gsa_pkg::SLOT_OUT_W-1:0] : '0;
      out_status <= res_status;
    end
  end

endmodule

>>> hw/rtl/generational_slot_allocator_core.sv
// Sequence: lookup, free and allocate of a never-used slot go from capture
// straight to evaluation; allocate from the free stack reads the stack top first.
// The result loads at commit, which waits while the result register is full.
// A new request is taken only once the last one has committed.
// Reset: synchronous; counters and handshake clear at once, no clearing pass,
// since the used-slot count marks which table entries hold data.
// ----------------------------------------------------------------------------
// Generational slot allocator
// Hands out generation-tagged handles over a fixed slot table, checks and
// frees them, and keeps freed slots on a LIFO stack for reuse.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core #(
  parameter int SLOT_COUNT = 64
) (
  input  logic      clk,
  input  logic      rst,
  gsa_req_if.sink   req,
  gsa_rsp_if.source rsp
);

  gsa_pkg::gsa_cmd_t cmd;
  gsa_pkg::gsa_sts_t sts;

  // Request sequencing.
  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .sts      (sts),
    .in_ready (req.ready),
    .cmd      (cmd)
  );

  // Tables, counters and result register.
  gsa_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_mode   (req.mode),
    .req_handle (req.handle),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_handle (rsp.result_handle),
    .out_slot   (rsp.slot),
    .out_status (rsp.status)
  );

endmodule
